// ===== hw/rtl/source_address_packet_counter_unit_macros.svh =====
// Assertion macros for the per-source packet counter.
// Needs clk and rst_n in the scope of use.
`ifndef SOURCE_ADDRESS_PACKET_COUNTER_UNIT_MACROS_SVH
`define SOURCE_ADDRESS_PACKET_COUNTER_UNIT_MACROS_SVH

// condition holds every cycle out of reset
`define SAPC_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// pre in one cycle implies post in the next
`define SAPC_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/sapc_pkg.sv =====
// Shared types, status codes and helpers for the per-source packet counter.
// No dependencies.
`default_nettype none

package sapc_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_NEW  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] seconds_elapsed;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [7:0]  entry_index;
    logic [31:0] entry_count;
    logic [31:0] total_packets;
  } out_beat_t;

  // lookup token moving down the cell chain
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [31:0] addr;
    logic [31:0] now;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] count;
  } probe_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sapc_cell.sv =====
// One table entry: address, count and last-seen time, plus one probe stage.
// Depends on sapc_pkg.
`default_nettype none

module sapc_cell #(
  parameter int TABLE_DEPTH = sapc_pkg::TABLE_DEPTH_DEF,
  parameter int IDX         = 0,
  localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [CW-1:0]   used,
  input  wire sapc_pkg::probe_t probe_in,
  output sapc_pkg::probe_t     probe_out
);

  logic [31:0]      addr_r;
  logic [31:0]      count_r;
  logic [31:0]      seen_r;
  sapc_pkg::probe_t probe_r;
  sapc_pkg::probe_t probe_nxt;

  logic filled;
  logic live;
  logic hit;
  logic ins;

  assign filled = used > CW'(IDX);
  assign live   = probe_in.valid && !probe_in.done;
  assign hit    = live && filled && (addr_r == probe_in.addr);
  assign ins    = live && !filled && (used == CW'(IDX));

  always_comb begin
    probe_nxt = probe_in;
    if (hit) begin
      probe_nxt.done   = 1'b1;
      probe_nxt.status = sapc_pkg::STATUS_HIT;
      probe_nxt.slot   = 8'(IDX);
      probe_nxt.count  = sapc_pkg::sat_inc(count_r);
    end else if (ins) begin
      probe_nxt.done   = 1'b1;
      probe_nxt.status = sapc_pkg::STATUS_NEW;
      probe_nxt.slot   = 8'(IDX);
      probe_nxt.count  = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      count_r <= sapc_pkg::sat_inc(count_r);
      seen_r  <= probe_in.now;
    end else if (ins) begin
      addr_r  <= probe_in.addr;
      count_r <= 32'd1;
      seen_r  <= probe_in.now;
    end
  end

  assign probe_out = probe_r;

endmodule

`default_nettype wire

// ===== hw/rtl/source_address_packet_counter_unit.sv =====
// Each input beat enters the cell chain, passes the registered probe stage of each cell in turn,
// and its result is registered into the output. One packet is in flight at a time: the probe walks
// the cell chain one entry per cycle, and input stalls until it has left the last cell.
// A finished result waits in a skid register while the output stalls; input stalls until it moves.
// Reset (synchronous, rst_n low) empties the table and zeroes the total.
`default_nettype none

module source_address_packet_counter_unit #(
  parameter int TABLE_DEPTH = sapc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sapc_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sapc_pkg::out_beat_t      out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  sapc_pkg::probe_t    probe [TABLE_DEPTH+1];
  sapc_pkg::out_beat_t res;

  logic [CW-1:0]       used_r, used_nxt;
  logic [31:0]         total_r, total_nxt;
  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  sapc_pkg::out_beat_t out_r, out_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  sapc_pkg::out_beat_t hold_r, hold_nxt;

  logic in_acc;
  logic out_acc;
  logic tail;

  assign in_stall = busy_r || hold_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign tail     = probe[TABLE_DEPTH].valid;

  always_comb begin
    probe[0]        = '0;
    probe[0].valid  = in_acc;
    probe[0].addr   = in_data.source_address;
    probe[0].now    = in_data.seconds_elapsed;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sapc_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .used      (used_r),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

  always_comb begin
    res.total_packets = total_r;
    if (probe[TABLE_DEPTH].done) begin
      res.lookup_status = probe[TABLE_DEPTH].status;
      res.entry_index   = probe[TABLE_DEPTH].slot;
      res.entry_count   = probe[TABLE_DEPTH].count;
    end else begin
      res.lookup_status = sapc_pkg::STATUS_FULL;
      res.entry_index   = 8'd0;
      res.entry_count   = 32'd0;
    end
  end

  always_comb begin
    used_nxt       = used_r;
    total_nxt      = total_r;
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;

    if (in_acc) begin
      busy_nxt  = 1'b1;
      total_nxt = sapc_pkg::sat_inc(total_r);
    end

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (hold_valid_r && (!out_valid_r || out_acc)) begin
      out_nxt        = hold_r;
      out_valid_nxt  = 1'b1;
      hold_valid_nxt = 1'b0;
    end

    if (tail) begin
      busy_nxt = 1'b0;
      if (probe[TABLE_DEPTH].done && probe[TABLE_DEPTH].status == sapc_pkg::STATUS_NEW) begin
        used_nxt = used_r + CW'(1);
      end
      if (out_valid_r && !out_acc) begin
        hold_nxt       = res;
        hold_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      total_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      total_r      <= total_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "source_address_packet_counter_unit_macros.svh"

  `SAPC_CHECK(a_used_bound, used_r <= CW'(TABLE_DEPTH), "fill count past table depth")
  `SAPC_CHECK(a_tail_busy, !tail || busy_r, "probe left chain with no packet in flight")
  `SAPC_CHECK(a_hold_out, !hold_valid_r || out_valid_r, "skid beat held while output empty")
  `SAPC_CHECK_NEXT(a_acc_busy, in_acc, busy_r, "packet accepted but chain not busy")

endmodule

`default_nettype wire
